### sv/ffsa_pkg.sv
package ffsa_pkg;

   localparam int MAX_SEGMENTS_DEFAULT = 32;
   localparam int SIZE_W   = 21;
   localparam int OFFSET_W = 20;
   localparam int STATUS_W = 3;
   localparam logic [SIZE_W-1:0] POOL_MAX   = 21'd1048576;
   localparam logic [SIZE_W-1:0] POOL_RESET = 21'd16384;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_NOFIT   = 3'd2,
      ST_TABLE   = 3'd3,
      ST_BADFREE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                req_type;
      logic [SIZE_W-1:0]   req_size;
      logic [OFFSET_W-1:0] block_offset;
   } req_type_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFFSET_W-1:0] grant_offset;
      logic [SIZE_W-1:0]   used_units;
   } rsp_type;

   // one table entry
   typedef struct packed {
      logic              free;
      logic [SIZE_W-1:0] size;
   } seg_type;

   // command fields for the cell row; the cells themselves take rot and load
   typedef struct packed {
      logic init;      // load one free segment of init_size
      logic rotate;    // every cell takes its upstream neighbour
      logic ins;       // insert split at cell 0 (head)
      logic merge;     // head absorbs the next segment
      logic set_used;  // head marked allocated
      logic set_free;  // head marked free
      logic trim;      // head size := trim_size
   } cell_ctrl_type;

endpackage

### sv/first_fit_segment_allocator.sv
// First-fit segment allocator. The segment table is a ring of MAX_SEGMENTS
// cells with the entry under inspection at the head (cell 0). Each request
// walks the ring one full lap, so the head visits every entry in address order.
// An allocate takes the first free segment that fits and splits it at the
// head when that segment is larger. A free marks the head and folds any free
// neighbour into it. rsp_valid is registered from S_DONE, which follows the
// lap; a successful free holds the lap while it marks the segment and while it
// folds in each free neighbour. busy stays high until the result is shown. The
// result is shown for exactly one cycle, and the receiver cannot stall it. The
// next request can be accepted on the edge that ends that cycle. Reset and a
// pool_size write both leave one free segment covering the pool. After reset,
// busy is high for one cycle while that segment is loaded.
// Write pool_size only while busy is low.
module first_fit_segment_allocator #(
   parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  ffsa_pkg::req_type_type       req_data,
   output logic                         rsp_valid,
   output ffsa_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [ffsa_pkg::SIZE_W-1:0]  csr_wdata
);
   import ffsa_pkg::*;

   localparam int IW = $clog2(MAX_SEGMENTS + 1);

   state_type state_ff, state_in;
   seg_type   seg [MAX_SEGMENTS];
   seg_type   load_seg [MAX_SEGMENTS];
   logic      load [MAX_SEGMENTS];
   logic      rot;
   logic      accept;

   logic [SIZE_W-1:0] pool_ff, pool_in;
   logic [SIZE_W-1:0] used_ff, used_in;
   logic [IW-1:0]     count_ff, count_in;
   logic [IW-1:0]     step_ff, step_in;    // ring position of head
   logic [SIZE_W-1:0] addr_ff, addr_in;    // running start offset
   logic              done_ff, done_in;    // operation already applied
   status_type        st_ff, st_in;
   logic [OFFSET_W-1:0] grant_ff, grant_in;
   req_type_type      req_ff;
   logic              rsp_valid_ff;
   logic              init_pend_ff;
   logic [IW-1:0]     unvisited;           // entries from the head up, not yet passed

   // head = cell 0, next = cell 1; rotate moves cell k+1 into cell k
   // so the head always walks forward through the address order
   logic [SIZE_W-1:0] wdata_clip;
   logic [SIZE_W:0]   sum_used;

   always_comb begin
      wdata_clip = csr_wdata;
      if (csr_wdata == '0) wdata_clip = SIZE_W'(1);
      else if (csr_wdata > POOL_MAX) wdata_clip = POOL_MAX;
   end

   assign sum_used = {1'b0, used_ff} + {1'b0, req_ff.req_size};
   assign accept = start && !busy;

   genvar g;
   generate
      for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
         ffsa_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .rot      (rot),
            .up_seg   (seg[(g + 1) % MAX_SEGMENTS]),
            .load     (load[g]),
            .load_seg (load_seg[g]),
            .seg      (seg[g])
         );
      end
   endgenerate

   logic active_head;
   assign active_head = step_ff < count_ff;
   assign unvisited = count_ff - step_ff;

   // The scan stage applies at most one edit per cycle, always at the head.
   // Passed entries sit at the tail end of the ring, the last one in the top
   // cell; a split or a fold moves only the passed entries or only the
   // entries still ahead, and the empty slots between them absorb the change.
   logic ins_now;

   always_comb begin
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
         load[k] = 1'b0;
         load_seg[k] = seg[(k + 1) % MAX_SEGMENTS];
      end
      rot = 1'b0;
      ins_now = 1'b0;
      used_in = used_ff;
      count_in = count_ff;
      step_in = step_ff;
      addr_in = addr_ff;
      done_in = done_ff;
      st_in = st_ff;
      grant_in = grant_ff;
      pool_in = pool_ff;

      case (state_ff)
         S_IDLE: begin
            step_in = '0;
            addr_in = '0;
            done_in = 1'b0;
            grant_in = '0;
            if (accept) begin
               if (req_data.req_type == 1'b0) begin
                  if ({1'b0, used_ff} + {1'b0, req_data.req_size} > {1'b0, pool_ff}) begin
                     st_in = ST_FULL; done_in = 1'b1;
                  end else if (req_data.req_size == '0) begin
                     st_in = ST_NOFIT; done_in = 1'b1;
                  end else begin
                     st_in = ST_NOFIT;
                  end
               end else begin
                  st_in = ST_BADFREE;
               end
            end
         end
         S_SCAN: begin
            rot = 1'b1;
            step_in = step_ff + IW'(1);
            if (active_head) addr_in = addr_ff + seg[0].size;
            if (!done_ff && active_head) begin
               if (req_ff.req_type == 1'b0) begin
                  if (seg[0].free && seg[0].size >= req_ff.req_size) begin
                     done_in = 1'b1;
                     if (seg[0].size > req_ff.req_size) begin
                        if (count_ff >= IW'(MAX_SEGMENTS)) begin
                           st_in = ST_TABLE;
                        end else begin
                           ins_now = 1'b1;
                           st_in = ST_OK;
                           grant_in = addr_ff[OFFSET_W-1:0];
                           used_in = sum_used[SIZE_W-1:0];
                           count_in = count_ff + IW'(1);
                        end
                     end else begin
                        st_in = ST_OK;
                        grant_in = addr_ff[OFFSET_W-1:0];
                        used_in = sum_used[SIZE_W-1:0];
                        load[MAX_SEGMENTS-1] = 1'b1;
                        load_seg[MAX_SEGMENTS-1] = '{free: 1'b0, size: seg[0].size};
                     end
                  end
               end else begin
                  if (addr_ff == {1'b0, req_ff.block_offset}) begin
                     done_in = 1'b1;
                     if (!seg[0].free) begin
                        st_in = ST_OK;
                        used_in = (used_ff >= req_ff.req_size) ?
                                  used_ff - req_ff.req_size : '0;
                        // mark in place so the head still meets both neighbours
                        rot = 1'b0;
                        load[0] = 1'b1;
                        load_seg[0] = '{free: 1'b1, size: seg[0].size};
                        addr_in = addr_ff;
                        step_in = step_ff;
                     end
                  end else if (addr_ff > {1'b0, req_ff.block_offset}) begin
                     done_in = 1'b1;
                  end
               end
            end
            // split: allocated part joins the passed entries, remainder stays at head
            if (ins_now) begin
               rot = 1'b0;
               load[0] = 1'b1;
               load_seg[0] = '{free: 1'b1, size: seg[0].size - req_ff.req_size};
               // passed entries and empty slots move down one to make room
               for (int k = 1; k < MAX_SEGMENTS - 1; k++) begin
                  load[k] = (IW'(k) >= unvisited);
               end
               load[MAX_SEGMENTS-1] = 1'b1;
               load_seg[MAX_SEGMENTS-1] = '{free: 1'b0, size: req_ff.req_size};
               addr_in = addr_ff + req_ff.req_size;
               step_in = step_ff + IW'(1);
            end
            // after a free, fold a free head into the free entry just passed
            if (done_ff && req_ff.req_type && st_ff == ST_OK && active_head
                && step_ff != '0 && seg[0].free && seg[MAX_SEGMENTS-1].free) begin
               rot = 1'b0;
               for (int k = 0; k < MAX_SEGMENTS - 1; k++) begin
                  load[k] = (IW'(k) < unvisited);
                  load_seg[k] = (IW'(k + 1) < unvisited) ? seg[k + 1] : '0;
               end
               load[MAX_SEGMENTS-1] = 1'b1;
               load_seg[MAX_SEGMENTS-1] = '{free: 1'b1,
                                           size: seg[MAX_SEGMENTS-1].size + seg[0].size};
               count_in = count_ff - IW'(1);
               step_in = step_ff;
            end
         end
         default: ;
      endcase

      // reset loads the default pool through the same path as a csr write
      if (csr_we || init_pend_ff) begin
         pool_in = csr_we ? wdata_clip : pool_ff;
         used_in = '0;
         count_in = IW'(1);
         for (int k = 0; k < MAX_SEGMENTS; k++) begin
            load[k] = 1'b1;
            load_seg[k] = '0;
         end
         load_seg[0] = '{free: 1'b1, size: pool_in};
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_SCAN;
         S_SCAN:  if (step_in == IW'(MAX_SEGMENTS)) state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pool_ff <= POOL_RESET;
         used_ff <= '0;
         count_ff <= IW'(1);
         step_ff <= '0;
         addr_ff <= '0;
         done_ff <= 1'b0;
         st_ff <= ST_OK;
         grant_ff <= '0;
         rsp_valid_ff <= 1'b0;
         init_pend_ff <= 1'b1;
      end else begin
         state_ff <= init_pend_ff ? S_IDLE : state_in;
         pool_ff <= pool_in;
         used_ff <= used_in;
         count_ff <= count_in;
         step_ff <= step_in;
         addr_ff <= addr_in;
         done_ff <= done_in;
         st_ff <= st_in;
         grant_ff <= grant_in;
         rsp_valid_ff <= (state_ff == S_DONE);
         init_pend_ff <= 1'b0;
      end
      if (accept) req_ff <= req_data;
   end

   assign busy = (state_ff != S_IDLE) || init_pend_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.status = st_ff;
   assign rsp_data.grant_offset = (st_ff == ST_OK && !req_ff.req_type) ? grant_ff : '0;
   assign rsp_data.used_units = used_ff;

   a_busy_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> busy) else $error("busy low during scan");
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= IW'(MAX_SEGMENTS)) else $error("count range");
   a_used: assert property (@(posedge clock) disable iff (reset)
      used_ff <= pool_ff || init_pend_ff) else $error("used over pool");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy while showing a result");
endmodule

### sv/ffsa_cell.sv
// One table slot. The row forms a ring; rotating brings every segment past the head.
module ffsa_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rot,
   input  ffsa_pkg::seg_type    up_seg,
   input  logic                 load,
   input  ffsa_pkg::seg_type    load_seg,
   output ffsa_pkg::seg_type    seg
);
   import ffsa_pkg::*;

   seg_type seg_ff, seg_in;

   always_comb begin
      seg_in = seg_ff;
      if (load) begin
         seg_in = load_seg;
      end else if (rot) begin
         seg_in = up_seg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= '0;
      end else begin
         seg_ff <= seg_in;
      end
   end

   assign seg = seg_ff;
endmodule
